// ===== src/es2cal_pkg.sv =====
// package: stage record types and calendar constants for the epoch seconds to calendar pipeline
`timescale 1ns / 1ps
package es2cal_pkg;

   // field widths of the request and response
   localparam int EpochWidth  = 31;
   localparam int YearWidth   = 11;
   localparam int MonthWidth  = 4;
   localparam int DayWidth    = 5;
   localparam int HourWidth   = 5;
   localparam int MinuteWidth = 6;
   localparam int SecondWidth = 6;

   // seconds per day is 128 * 675: shift out 7 bits, then divide by 675
   localparam int          DayShift  = 7;
   localparam logic [24:0] DayRecip  = 25'd25451658;   // floor(2^34 / 675)
   localparam int          DayRecipK = 34;
   localparam logic [9:0]  DayOdd    = 10'd675;

   // seconds per hour is 16 * 225
   localparam logic [12:0] HourRecip  = 13'd4661;       // ceil(2^20 / 225)
   localparam int          HourRecipK = 20;
   localparam logic [11:0] SecsHour   = 12'd3600;

   // seconds per minute is 4 * 15
   localparam logic [10:0] MinRecip  = 11'd1093;        // ceil(2^14 / 15)
   localparam int          MinRecipK = 14;
   localparam logic [5:0]  SecsMin   = 6'd60;

   // days counted from 1968-01-01, the leap year just before the epoch;
   // up to 2038 every four-year block holds 1461 days (2000 is a leap year)
   localparam logic [9:0]  EpochDayOffset = 10'd731;
   localparam logic [14:0] QuadRecip      = 15'd22967;  // ceil(2^25 / 1461)
   localparam int          QuadRecipK     = 25;
   localparam logic [10:0] QuadDays       = 11'd1461;
   localparam logic [10:0] BaseYear       = 11'd1968;

   // first day of each following year inside a four-year block
   localparam logic [10:0] YearStart1 = 11'd366;
   localparam logic [10:0] YearStart2 = 11'd731;
   localparam logic [10:0] YearStart3 = 11'd1096;

   // days before each month
   localparam logic [8:0] CumLeap [13] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};
   localparam logic [8:0] CumCommon [13] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};

   localparam int StageCount = 6;

   typedef struct packed {
      logic [23:0] hi_secs;
      logic [6:0]  lo_secs;
      logic [14:0] day_est;
   } s1_type;

   typedef struct packed {
      logic [14:0] days;
      logic [16:0] sod;
   } s2_type;

   typedef struct packed {
      logic [16:0] sod;
      logic [4:0]  hour;
      logic [14:0] days68;
      logic [4:0]  quad;
   } s3_type;

   typedef struct packed {
      logic [11:0] rem_hour;
      logic [4:0]  hour;
      logic [4:0]  quad;
      logic [10:0] quad_day;
   } s4_type;

   typedef struct packed {
      logic [11:0] rem_hour;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [10:0] year;
      logic [8:0]  doy;
      logic        leap;
   } s5_type;

   typedef struct packed {
      logic [10:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } s6_type;

   // days before month index idx (0 is January)
   function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
      logic [8:0] val;
      val = leap ? CumLeap[idx] : CumCommon[idx];
      return val;
   endfunction

endpackage

// ===== src/epoch_seconds_to_calendar.sv =====
// top level: six-stage pipeline turning epoch seconds into a calendar date and time of day
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_ready  req_epoch_seconds
//  rsp_      out        rsp_valid / rsp_ready  rsp_cal_year .. rsp_cal_second
//
//  one request enters per cycle unless a stall holds the pipe; each response leaves from s6_ff
//  the pipeline moves as one block: it advances when the output register is empty or taken
//  a stall on rsp_ready freezes every stage, so nothing is dropped or repeated
//  reset clears only the stage valid bits; data registers are left as they are
//
module epoch_seconds_to_calendar (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [es2cal_pkg::EpochWidth-1:0]   req_epoch_seconds,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [es2cal_pkg::YearWidth-1:0]    rsp_cal_year,
   output logic [es2cal_pkg::MonthWidth-1:0]   rsp_cal_month,
   output logic [es2cal_pkg::DayWidth-1:0]     rsp_cal_day,
   output logic [es2cal_pkg::HourWidth-1:0]    rsp_cal_hour,
   output logic [es2cal_pkg::MinuteWidth-1:0]  rsp_cal_minute,
   output logic [es2cal_pkg::SecondWidth-1:0]  rsp_cal_second
);
   import es2cal_pkg::*;

   logic                  advance;
   logic [StageCount-1:0] valid_ff, valid_in;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;

   // stage scratch
   logic [48:0] day_prod;
   logic [23:0] day_rem;
   logic [25:0] hour_prod;
   logic [29:0] quad_prod;
   logic [16:0] hour_secs;
   logic [20:0] min_prod;
   logic [1:0]  year_idx;
   logic [10:0] year_base;
   logic [3:0]  month;
   logic [11:0] min_secs;

   // whole pipe moves together; holds only while the output is full and not taken
   assign advance   = !valid_ff[StageCount-1] || rsp_ready;
   assign req_ready = advance;
   assign valid_in  = {valid_ff[StageCount-2:0], req_valid};

   // stage 1: day estimate from a reciprocal multiply, may be one low
   always_comb begin
      s1_in.hi_secs = req_epoch_seconds[EpochWidth-1:DayShift];
      s1_in.lo_secs = req_epoch_seconds[DayShift-1:0];
      day_prod      = 49'(s1_in.hi_secs) * 49'(DayRecip);
      s1_in.day_est = day_prod[DayRecipK+14:DayRecipK];
   end

   // stage 2: correct the day count and rebuild the second of the day
   always_comb begin
      day_rem = s1_ff.hi_secs - 24'(25'(s1_ff.day_est) * 25'(DayOdd));
      if (day_rem >= 24'(DayOdd)) begin
         s2_in.days = s1_ff.day_est + 15'd1;
         s2_in.sod  = {day_rem[9:0] - DayOdd, s1_ff.lo_secs};
      end else begin
         s2_in.days = s1_ff.day_est;
         s2_in.sod  = {day_rem[9:0], s1_ff.lo_secs};
      end
   end

   // stage 3: hour of day, and four-year block of the day count
   always_comb begin
      hour_prod      = 26'(s2_ff.sod[16:4]) * 26'(HourRecip);
      s3_in.sod      = s2_ff.sod;
      s3_in.hour     = hour_prod[HourRecipK+4:HourRecipK];
      s3_in.days68   = s2_ff.days + 15'(EpochDayOffset);
      quad_prod      = 30'(s3_in.days68) * 30'(QuadRecip);
      s3_in.quad     = quad_prod[QuadRecipK+4:QuadRecipK];
   end

   // stage 4: seconds left in the hour, day within the four-year block
   always_comb begin
      hour_secs      = 17'(s3_ff.hour) * 17'(SecsHour);
      s4_in.rem_hour = 12'(s3_ff.sod - hour_secs);
      s4_in.hour     = s3_ff.hour;
      s4_in.quad     = s3_ff.quad;
      s4_in.quad_day = 11'(s3_ff.days68 - 15'(16'(s3_ff.quad) * 16'(QuadDays)));
   end

   // stage 5: minute, year and day of year
   always_comb begin
      min_prod       = 21'(s4_ff.rem_hour[11:2]) * 21'(MinRecip);
      s5_in.rem_hour = s4_ff.rem_hour;
      s5_in.hour     = s4_ff.hour;
      s5_in.minute   = min_prod[MinRecipK+5:MinRecipK];
      priority if (s4_ff.quad_day >= YearStart3) begin
         year_idx  = 2'd3;
         year_base = YearStart3;
      end else if (s4_ff.quad_day >= YearStart2) begin
         year_idx  = 2'd2;
         year_base = YearStart2;
      end else if (s4_ff.quad_day >= YearStart1) begin
         year_idx  = 2'd1;
         year_base = YearStart1;
      end else begin
         year_idx  = 2'd0;
         year_base = 11'd0;
      end
      s5_in.year = BaseYear + {4'd0, s4_ff.quad, 2'b00} + 11'(year_idx);
      s5_in.doy  = 9'(s4_ff.quad_day - year_base);
      s5_in.leap = (year_idx == 2'd0);
   end

   // stage 6: month search over the cumulative table, second of minute
   always_comb begin
      month = 4'd1;
      for (int i = 1; i < 12; i++) begin
         if (s5_ff.doy >= cum_days(s5_ff.leap, 4'(i))) begin
            month = 4'(i + 1);
         end
      end
      s6_in.year   = s5_ff.year;
      s6_in.month  = month;
      s6_in.day    = 5'(s5_ff.doy - cum_days(s5_ff.leap, month - 4'd1) + 9'd1);
      s6_in.hour   = s5_ff.hour;
      s6_in.minute = s5_ff.minute;
      min_secs     = 12'(s5_ff.minute) * 12'(SecsMin);
      s6_in.second = 6'(s5_ff.rem_hour - min_secs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   assign rsp_valid      = valid_ff[StageCount-1];
   assign rsp_cal_year   = s6_ff.year;
   assign rsp_cal_month  = s6_ff.month;
   assign rsp_cal_day    = s6_ff.day;
   assign rsp_cal_hour   = s6_ff.hour;
   assign rsp_cal_minute = s6_ff.minute;
   assign rsp_cal_second = s6_ff.second;

endmodule

// ===== tb/tb_top.sv =====
// testbench: directed and random checks of the epoch seconds to calendar pipeline
`timescale 1ns / 1ps

module tb_top;
   import es2cal_pkg::*;

   // run limits: this bound is many times the worst correct run
   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 24;
   localparam int ReportLimit = 10;

   localparam int unsigned SecsPerDay  = 86400;
   localparam int unsigned SecsPerHour = 3600;
   localparam int unsigned SecsPerMin  = 60;
   localparam int unsigned FirstYear   = 1970;
   localparam int unsigned LastDay     = 24855;  // last day that starts below 2^31 seconds

   // one calendar response, at the widths of the response ports
   typedef struct packed {
      logic [YearWidth-1:0]   year;
      logic [MonthWidth-1:0]  month;
      logic [DayWidth-1:0]    day;
      logic [HourWidth-1:0]   hour;
      logic [MinuteWidth-1:0] minute;
      logic [SecondWidth-1:0] second;
   } calendar_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [EpochWidth-1:0]   req_epoch_seconds = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [YearWidth-1:0]    rsp_cal_year;
   logic [MonthWidth-1:0]   rsp_cal_month;
   logic [DayWidth-1:0]     rsp_cal_day;
   logic [HourWidth-1:0]    rsp_cal_hour;
   logic [MinuteWidth-1:0]  rsp_cal_minute;
   logic [SecondWidth-1:0]  rsp_cal_second;

   // dates predicted for accepted requests, oldest first
   calendar_type expected_dates [$];

   // percentage of cycles in which the sender holds back / the receiver stalls
   int idle_pct  = 0;
   int stall_pct = 0;

   int error_count   = 0;
   int request_count = 0;
   int checked_count = 0;
   int cycle_count   = 0;

   epoch_seconds_to_calendar u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cal_year      (rsp_cal_year),
      .rsp_cal_month     (rsp_cal_month),
      .rsp_cal_day       (rsp_cal_day),
      .rsp_cal_hour      (rsp_cal_hour),
      .rsp_cal_minute    (rsp_cal_minute),
      .rsp_cal_second    (rsp_cal_second)
   );

   // 2 ns period
   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // calendar arithmetic for the prediction
   // ------------------------------------------------------------------

   // leap rule of this prediction: every 4th year, not every 100th, but every
   // 400th, and never a multiple of 4000
   function automatic bit is_leap_year(input int unsigned yr);
      if (yr % 4000 == 0) return 1'b0;
      if (yr % 400 == 0) return 1'b1;
      if (yr % 100 == 0) return 1'b0;
      return (yr % 4 == 0);
   endfunction

   // number of leap days in the years 1 .. yr-1
   function automatic int unsigned leap_days_before(input int unsigned yr);
      int unsigned prev;
      prev = (yr == 0) ? 0 : yr - 1;
      return prev / 4 - prev / 100 + prev / 400 - prev / 4000;
   endfunction

   // days of the year before month index idx (0 is january, 12 the whole year)
   function automatic int unsigned days_before_month(input bit leap, input int unsigned idx);
      int unsigned common;
      case (idx)
         0:       common = 0;
         1:       common = 31;
         2:       common = 59;
         3:       common = 90;
         4:       common = 120;
         5:       common = 151;
         6:       common = 181;
         7:       common = 212;
         8:       common = 243;
         9:       common = 273;
         10:      common = 304;
         11:      common = 334;
         default: common = 365;
      endcase
      // february's extra day shifts every later month start
      return common + ((leap && idx >= 2) ? 1 : 0);
   endfunction

   function automatic calendar_type predict_calendar(input logic [EpochWidth-1:0] secs);
      int unsigned  total, days, rest, hr, mn, sc, yr, doy, mon;
      bit           leap;
      calendar_type cal;
      total = secs;
      days  = total / SecsPerDay;
      rest  = total - days * SecsPerDay;
      hr    = rest / SecsPerHour;
      rest  = rest - hr * SecsPerHour;
      mn    = rest / SecsPerMin;
      sc    = rest - mn * SecsPerMin;

      // move to days since year zero, guess low with 366-day years, then walk up
      days = days + FirstYear * 365 + leap_days_before(FirstYear);
      yr   = days / 366;
      doy  = days - (365 * yr + leap_days_before(yr));
      while (doy >= (is_leap_year(yr) ? 366 : 365)) begin
         doy = doy - (is_leap_year(yr) ? 366 : 365);
         yr  = yr + 1;
      end

      leap = is_leap_year(yr);
      mon  = 1;
      while (mon < 12 && doy >= days_before_month(leap, mon)) mon = mon + 1;

      cal.year   = yr[YearWidth-1:0];
      cal.month  = mon[MonthWidth-1:0];
      cal.day    = 5'(doy - days_before_month(leap, mon - 1) + 1);
      cal.hour   = hr[HourWidth-1:0];
      cal.minute = mn[MinuteWidth-1:0];
      cal.second = sc[SecondWidth-1:0];
      return cal;
   endfunction

   // ------------------------------------------------------------------
   // failures: the first few are reported in full, the rest only counted
   // ------------------------------------------------------------------
   task automatic note_failure(input string what);
      error_count++;
      if (error_count <= ReportLimit) $display("ERROR at cycle %0d: %s", cycle_count, what);
   endtask

   // ------------------------------------------------------------------
   // request side: entered at a falling edge, leaves at a falling edge with
   // req_valid still high, so back-to-back requests never drop valid
   // ------------------------------------------------------------------
   task automatic send_epoch(input logic [EpochWidth-1:0] secs);
      // random hold-off, redrawn at each falling edge
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_dates.push_back(predict_calendar(secs));
      request_count++;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // response side: back-pressure is redrawn every cycle
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // compare every accepted response with the oldest prediction
   always @(posedge clock) begin : check_responses
      calendar_type want;
      calendar_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_cal_year, rsp_cal_month, rsp_cal_day,
                 rsp_cal_hour, rsp_cal_minute, rsp_cal_second};
         if (expected_dates.size() == 0) begin
            note_failure($sformatf("response %0d-%0d-%0d %0d:%0d:%0d with no request pending",
                                   got.year, got.month, got.day,
                                   got.hour, got.minute, got.second));
         end else begin
            want = expected_dates.pop_front();
            checked_count++;
            if (got.year != want.year || got.month != want.month || got.day != want.day ||
                got.hour != want.hour || got.minute != want.minute ||
                got.second != want.second) begin
               note_failure($sformatf(
                  "expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                  want.year, want.month, want.day, want.hour, want.minute, want.second,
                  got.year, got.month, got.day, got.hour, got.minute, got.second));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d responses still outstanding",
                  cycle_count, expected_dates.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // zero, the top of the range, the minute / hour / day roll-overs and
   // alternating bit patterns so that every input bit sits at both values
   task automatic test_field_extremes();
      logic [EpochWidth-1:0] points [12];
      points = '{31'd0, 31'd1, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400,
                 31'h2AAAAAAA, 31'h55555555, 31'h7FFFFFFE, 31'h7FFFFFFF};
      foreach (points[i]) send_epoch(points[i]);
   endtask

   // leap days, month ends and year ends, including 2000 (a leap century)
   // and the first day of 2038
   task automatic test_calendar_boundaries();
      logic [EpochWidth-1:0] points [12];
      points = '{31'd68169599,   // 1972-02-28 23:59:59
                 31'd68169600,   // 1972-02-29
                 31'd94694399,   // 1972-12-31 23:59:59
                 31'd94694400,   // 1973-01-01
                 31'd946684799,  // 1999-12-31 23:59:59
                 31'd951782400,  // 2000-02-29
                 31'd951868799,  // 2000-02-29 23:59:59
                 31'd951868800,  // 2000-03-01
                 31'd978307199,  // 2000-12-31 23:59:59
                 31'd978307200,  // 2001-01-01
                 31'd2145916799, // 2037-12-31 23:59:59
                 31'd2145916800};// 2038-01-01
      foreach (points[i]) send_epoch(points[i]);
   endtask

   // random seconds: a mix of uniform values, instants next to midnight and
   // instants next to the start of a random month
   task automatic test_random_traffic(input int count, input int sender_idle,
                                      input int receiver_stall);
      int unsigned pick, yr, mon, total_days, base;
      int          offset;
      longint      instant;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      for (int n = 0; n < count; n++) begin
         pick   = $urandom_range(99);
         base   = 0;
         offset = 0;
         if (pick < 40) begin
            base = $urandom & 32'h7FFF_FFFF;
         end else if (pick < 70) begin
            base   = $urandom_range(LastDay) * SecsPerDay;
            offset = int'($urandom_range(4)) - 2;
         end else begin
            // february 2038 and later lie beyond 31 bits
            yr  = $urandom_range(2038, FirstYear);
            mon = (yr == 2038) ? 1 : $urandom_range(12, 1);
            total_days = days_before_month(is_leap_year(yr), mon - 1);
            for (int unsigned y = FirstYear; y < yr; y++)
               total_days += is_leap_year(y) ? 366 : 365;
            base   = total_days * SecsPerDay;
            offset = int'($urandom_range(4)) - 2;
         end
         instant = longint'(base) + offset;
         if (instant < 0) instant = 0;
         if (instant > 64'h7FFF_FFFF) instant = 64'h7FFF_FFFF;
         send_epoch(instant[EpochWidth-1:0]);
      end
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_calendar_boundaries();
      // traffic mixes: free flowing, sparse requests, heavy back-pressure, both
      test_random_traffic(200, 0, 0);
      test_random_traffic(200, 87, 0);
      test_random_traffic(200, 0, 87);
      test_random_traffic(200, 31, 31);
      req_valid <= 1'b0;

      // let the pipeline empty, then watch a little longer for strays
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("sent %0d epoch values (directed extremes and boundaries, then random)",
               request_count);
      $display("checked %0d calendar responses under four idle and back-pressure mixes",
               checked_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d failures in total", error_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
